>>> hdl/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int PAD_W    = 5;
    localparam int CHAR_W   = 7;
    localparam int BCD_DIGS = 10;
    localparam int HEX_DIGS = VALUE_W / 4;

    localparam logic [OP_W-1:0] OP_UDEC = 2'd0;
    localparam logic [OP_W-1:0] OP_UHEX = 2'd1;
    localparam logic [OP_W-1:0] OP_SDEC = 2'd2;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A     = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [OP_W-1:0]    op_t;
    typedef logic [PAD_W-1:0]   pad_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic count;
        logic emit;
    } itoa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_hex;
        logic final_char;
    } itoa_sts_t;

    function automatic char_t digit_char(input logic [3:0] nib);
        char_t c;
        if (nib < 4'd10)
            c = ASCII_ZERO + char_t'(nib);
        else
            c = ASCII_A + char_t'(nib - 4'd10);
        return c;
    endfunction

endpackage

>>> hdl/itoa_in_if.sv
`timescale 1ns / 1ps

interface itoa_in_if import itoa_pkg::*; ();
    logic   valid;
    logic   ready;
    value_t value;
    op_t    operation;
    pad_t   pad_width;

    modport source (output valid, output value, output operation, output pad_width,
                    input ready);
    modport sink   (input valid, input value, input operation, input pad_width,
                    output ready);
endinterface

>>> hdl/itoa_out_if.sv
`timescale 1ns / 1ps

interface itoa_out_if import itoa_pkg::*; ();
    logic  valid;
    logic  ready;
    char_t character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

>>> hdl/itoa_dpath.sv
`timescale 1ns / 1ps

module itoa_dpath import itoa_pkg::*; #(
    parameter int MAX_PAD_WIDTH = 16
) (
    input  logic      clk,
    input  value_t    value,
    input  op_t       operation,
    input  pad_t      pad_width,
    input  itoa_cmd_t cmd,
    output itoa_sts_t sts,
    output char_t     character,
    output logic      last
);

    localparam int CW = ($clog2(MAX_PAD_WIDTH + 1) > 4) ? $clog2(MAX_PAD_WIDTH + 1) : 4;
    localparam logic [5:0] MAX_PAD = 6'(MAX_PAD_WIDTH);

    value_t                  bin_reg;
    logic [4*BCD_DIGS-1:0]   bcd_reg;
    logic [3:0]              dig_reg [BCD_DIGS];
    logic                    neg_reg;
    logic                    hex_reg;
    logic [CW-1:0]           pad_reg;
    logic [CW-1:0]           pos_reg;
    char_t                   char_reg;
    logic                    last_reg;

    logic [4*BCD_DIGS-1:0]   bcd_adj;
    logic [4*BCD_DIGS-1:0]   hex_ext;
    logic [3:0]              dig_src [BCD_DIGS];
    logic [3:0]              ndig;
    logic [CW-1:0]           total;
    logic [3:0]              cur_dig;
    logic [5:0]              pad_ext;

    // add-3 correction before each shift of the double-dabble
    always_comb
    begin
        for (int i = 0; i < BCD_DIGS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign hex_ext = {{(4*BCD_DIGS-VALUE_W){1'b0}}, bin_reg};

    // significant digit count (at least one)
    always_comb
    begin
        for (int i = 0; i < BCD_DIGS; i++)
        begin
            if (hex_reg)
                dig_src[i] = (i < HEX_DIGS) ? hex_ext[4*i +: 4] : 4'd0;
            else
                dig_src[i] = bcd_reg[4*i +: 4];
        end
        ndig = 4'd1;
        for (int i = 0; i < BCD_DIGS; i++)
        begin
            if (dig_src[i] != 4'd0)
                ndig = 4'(i + 1);
        end
        if (hex_reg && pad_reg > CW'(ndig))
            total = pad_reg;
        else
            total = CW'(ndig);
    end

    assign pad_ext = {1'b0, pad_width};
    assign cur_dig = (pos_reg < CW'(BCD_DIGS)) ? dig_reg[pos_reg[3:0]] : 4'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (operation == OP_SDEC && value[VALUE_W-1])
            begin
                bin_reg <= ~value + value_t'(1);
                neg_reg <= 1'b1;
            end
            else
            begin
                bin_reg <= value;
                neg_reg <= 1'b0;
            end
            hex_reg <= (operation == OP_UHEX);
            pad_reg <= (pad_ext > MAX_PAD) ? CW'(MAX_PAD) : CW'(pad_ext);
            bcd_reg <= '0;
        end
        else if (cmd.shift)
        begin
            {bcd_reg, bin_reg} <= {bcd_adj[4*BCD_DIGS-2:0], bin_reg, 1'b0};
        end

        if (cmd.count)
        begin
            for (int i = 0; i < BCD_DIGS; i++)
                dig_reg[i] <= dig_src[i];
            pos_reg <= total - CW'(1);
        end

        if (cmd.emit)
        begin
            if (neg_reg)
            begin
                char_reg <= ASCII_MINUS;
                last_reg <= 1'b0;
                neg_reg  <= 1'b0;
            end
            else
            begin
                char_reg <= digit_char(cur_dig);
                last_reg <= (pos_reg == '0);
                pos_reg  <= pos_reg - CW'(1);
            end
        end
    end

    assign sts.is_hex     = hex_reg;
    assign sts.final_char = !neg_reg && (pos_reg == '0);
    assign character      = char_reg;
    assign last           = last_reg;

endmodule

>>> hdl/itoa_ctrl.sv
`timescale 1ns / 1ps

module itoa_ctrl import itoa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    output logic      out_valid,
    input  op_t       operation,
    input  itoa_sts_t sts,
    output itoa_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CONV  = 2'd1;
    localparam logic [1:0] S_COUNT = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    localparam logic [4:0] LAST_ITER = 5'(VALUE_W - 1);

    logic [1:0] state_reg, state_next;
    logic [4:0] iter_reg, iter_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    iter_next = '0;
                    // hex digits are the nibbles themselves
                    state_next = (operation == OP_UHEX) ? S_COUNT : S_CONV;
                end
            end
            S_CONV:
            begin
                cmd.shift = 1'b1;
                iter_next = iter_reg + 5'd1;
                if (iter_reg == LAST_ITER)
                    state_next = S_COUNT;
            end
            S_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.final_char)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("character emitted over an untaken result");

    a_load_path: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_CONV || state_reg == S_COUNT))
        else $error("load not followed by conversion or count");

    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.final_char) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("final character did not return to idle");

    a_hex_skips_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) |-> !sts.is_hex)
        else $error("hex item entered decimal conversion");

endmodule

>>> hdl/integer_to_ascii_digits_top.sv
`timescale 1ns / 1ps
// Sequence: decimal items pass the double-dabble shift state S_CONV, then the digit-count
// state S_COUNT, then S_EMIT; hex items go from load straight to S_COUNT and S_EMIT.
// Throughput: one character per cycle once emitting, unless dout.ready holds the output;
// a new item is taken only after the final character of the last one has been emitted.
// Next input is taken while the final character still waits in the output register.
// Reset: rst_n async active low clears the controller and output valid; datapath registers are not reset.

module integer_to_ascii_digits_top import itoa_pkg::*; #(
    parameter int MAX_PAD_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    itoa_in_if.sink     din,
    itoa_out_if.source  dout
);

    itoa_cmd_t cmd;
    itoa_sts_t sts;

    itoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .out_ready (dout.ready),
        .out_valid (dout.valid),
        .operation (din.operation),
        .sts       (sts),
        .cmd       (cmd)
    );

    itoa_dpath #(
        .MAX_PAD_WIDTH (MAX_PAD_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .value     (din.value),
        .operation (din.operation),
        .pad_width (din.pad_width),
        .cmd       (cmd),
        .sts       (sts),
        .character (dout.character),
        .last      (dout.last)
    );

endmodule
